### rtl/double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
// No dependencies; included by the files that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/deq_pkg.sv
// Package of the double-ended queue: field widths, request and status codes,
// the internal command type and the state type of the back end. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KIND_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_LIST
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP,
        BK_LIST
    } bk_state_t;

endpackage

### rtl/deq_in_if.sv
// Request channel of the double-ended queue: valid, ready, kind and value.
// Depends on deq_pkg for the field widths.
`timescale 1ns / 1ps

interface deq_in_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::KIND_W-1:0]          kind;
    logic signed [deq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

### rtl/deq_out_if.sv
// Response channel of the double-ended queue: valid, ready, status, data, last.
// Depends on deq_pkg for the field widths.
`timescale 1ns / 1ps

interface deq_out_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::STATUS_W-1:0]        status;
    logic signed [deq_pkg::VALUE_W-1:0]  data;
    logic                                last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

### rtl/double_ended_queue.sv
// Channel    Dir  Payload               Transfer
// request    in   kind[2:0] value[31:0] valid && ready
// response   out  status data last      valid && ready
//
// A request passes the front register and the command queue. Pushes and
// empty or full outcomes are answered from idle; a pop passes BK_POP for
// the registered memory read port; a list reads its first entry, then
// gives one result per cycle while the response is free. Reset clears
// pointers, count and handshake state at once; no clearing pass. A stalled
// response holds the back end while the front end and queue keep filling.
// Top level of the double-ended queue. Depends on deq_pkg, the channel
// interfaces and the front, queue and back modules.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    deq_in_if.sink     request,
    deq_out_if.source  response
);
    import deq_pkg::*;

    logic fr_valid;
    logic fr_ready;
    cmd_t fr_cmd;
    logic bk_valid;
    logic bk_ready;
    cmd_t bk_cmd;

    deq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    deq_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_cmd    (bk_cmd)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (bk_valid),
        .cmd_ready (bk_ready),
        .cmd       (bk_cmd),
        .response  (response)
    );

endmodule

### rtl/deq_front.sv
// Front end: takes request transfers, decodes the kind into a command and
// drops unused codes. Depends on deq_pkg and deq_in_if.
`timescale 1ns / 1ps

module deq_front (
    input  logic          clk,
    input  logic          rst_n,
    deq_in_if.sink        request,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output deq_pkg::cmd_t cmd
);
    import deq_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic known;
    op_t  op_dec;

    always_comb
    begin
        known  = 1'b1;
        op_dec = OP_LIST;
        case (request.kind)
            KIND_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
            KIND_PUSH_BACK:  op_dec = OP_PUSH_BACK;
            KIND_POP_FRONT:  op_dec = OP_POP_FRONT;
            KIND_POP_BACK:   op_dec = OP_POP_BACK;
            KIND_LIST:       op_dec = OP_LIST;
            default:         known  = 1'b0;
        endcase
    end

    assign request.ready = !valid_reg || cmd_ready;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (request.ready)
        begin
            valid_next     = request.valid && known;
            cmd_next.op    = op_dec;
            cmd_next.value = request.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

### rtl/deq_cmd_fifo.sv
// Two-slot command queue between the front end and the back end.
// Depends on deq_pkg for the command type.
`timescale 1ns / 1ps

module deq_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  deq_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output deq_pkg::cmd_t pop_cmd
);
    import deq_pkg::*;

    localparam int SLOTS = 2;
    localparam int PTR_W = $clog2(SLOTS);
    localparam logic [PTR_W:0] FULL_FILL = (PTR_W + 1)'(SLOTS);

    cmd_t               slot_reg [SLOTS];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [PTR_W:0]     fill_reg;
    logic [PTR_W:0]     fill_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = fill_reg != FULL_FILL;
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (PTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/deq_back.sv
// Back end: owns the circular entry memory, the head pointer and the entry
// count, carries out commands and drives the response register.
// Depends on deq_pkg, deq_out_if and double_ended_queue_defines.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_defines.svh"

module deq_back #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  deq_pkg::cmd_t cmd,
    deq_out_if.source     response
);
    import deq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W    = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_POS   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [PW-1:0]      head_reg;
    logic [PW-1:0]      head_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [PW-1:0]      idx_reg;
    logic [PW-1:0]      idx_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [STATUS_W-1:0]        out_status_next;
    logic signed [VALUE_W-1:0]  out_data_reg;
    logic signed [VALUE_W-1:0]  out_data_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic                       rd_en;
    logic [PW-1:0]              rd_addr;
    logic                       wr_en;
    logic [PW-1:0]              wr_addr;
    logic signed [VALUE_W-1:0]  wr_data;

    logic          out_free;
    logic          is_full;
    logic          is_empty;
    logic          is_pop;
    logic          list_last;
    logic [PW-1:0] head_dec;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[PW-1:0];
    endfunction

    assign out_free  = !out_valid_reg || response.ready;
    assign is_full   = count_reg == FULL_COUNT;
    assign is_empty  = count_reg == '0;
    assign is_pop    = cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK;
    assign list_last = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign head_dec  = (head_reg == '0) ? LAST_POS : head_reg - PW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free && !is_empty)
                begin
                    if (is_pop)
                    begin
                        state_next = BK_POP;
                    end
                    else if (cmd.op == OP_LIST)
                    begin
                        state_next = BK_LIST;
                    end
                end
            end
            BK_POP:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_LIST:
            begin
                if (out_free && list_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmd_ready       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        wr_data         = cmd.value;
        out_valid_next  = out_valid_reg && !response.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    case (cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = STATUS_FULL;
                                out_data_next   = '0;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (cmd.op == OP_PUSH_FRONT)
                                begin
                                    wr_addr   = head_dec;
                                    head_next = head_dec;
                                end
                                else
                                begin
                                    wr_addr = wrap_add(head_reg, count_reg[PW-1:0]);
                                end
                                count_next      = count_reg + CW'(1);
                                out_status_next = STATUS_OK;
                                out_data_next   = cmd.value;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_EMPTY;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (cmd.op == OP_POP_FRONT)
                                begin
                                    rd_addr   = head_reg;
                                    head_next = wrap_add(head_reg, PW'(1));
                                end
                                else
                                begin
                                    rd_addr = wrap_add(head_reg, PW'(count_reg - CW'(1)));
                                end
                            end
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_EMPTY;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = head_reg;
                                idx_next = '0;
                            end
                        end
                        default:
                        begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            BK_POP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_data_next   = rd_data_reg;
                    out_last_next   = 1'b1;
                end
            end
            BK_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_data_next   = rd_data_reg;
                    out_last_next   = list_last;
                    if (!list_last)
                    begin
                        idx_next = idx_reg + PW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = wrap_add(head_reg, idx_reg + PW'(1));
                    end
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign response.valid  = out_valid_reg;
    assign response.status = out_status_reg;
    assign response.data   = out_data_reg;
    assign response.last   = out_last_reg;

    `DEQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT, "entry count above depth")
    `DEQ_ASSERT(a_list_index, clk, rst_n, state_reg != BK_LIST || CW'(idx_reg) < count_reg, "list index beyond count")
    `DEQ_ASSERT_NEXT(a_list_frozen, clk, rst_n, state_reg == BK_LIST, $stable(count_reg) && $stable(head_reg), "queue changed during list")
    `DEQ_ASSERT_NEXT(a_pop_count, clk, rst_n, state_reg == BK_IDLE && state_next == BK_POP, count_reg == $past(count_reg) - CW'(1), "pop did not lower count")

endmodule
